// File: hw/rtl/ray_triangle_intersect_assert.svh
// ----------------------------------------------------------------------------
// ray_triangle_intersect_assert.svh
// assertion macros shared by the ray / triangle intersection rtl
// ----------------------------------------------------------------------------
`ifndef RAY_TRIANGLE_INTERSECT_ASSERT_SVH
`define RAY_TRIANGLE_INTERSECT_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define RTI_ASSERT_IMP(name, clk, rst_n, cond, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);
// next-cycle implication
`define RTI_ASSERT_NXT(name, clk, rst_n, cond, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);
`else
`define RTI_ASSERT_IMP(name, clk, rst_n, cond, prop, msg)
`define RTI_ASSERT_NXT(name, clk, rst_n, cond, prop, msg)
`endif
`endif

// File: hw/rtl/rti_pkg.sv
// ----------------------------------------------------------------------------
// rti_pkg
// shared types and constants of the ray / triangle intersection block
// ----------------------------------------------------------------------------
`default_nettype none

package rti_pkg;

    localparam int RTI_COORD_WIDTH = 16;
    localparam int THR_WIDTH       = 20;
    localparam logic [THR_WIDTH-1:0] THR_RESET = 20'd68719;
    localparam int OUT_WIDTH       = 8;

    typedef enum logic [1:0] {
        REG_VERTEX_A  = 2'd0,
        REG_VERTEX_B  = 2'd1,
        REG_VERTEX_C  = 2'd2,
        REG_THRESHOLD = 2'd3
    } t_reg_idx;

    typedef enum logic [2:0] {
        OUT_HIT       = 3'd0,
        OUT_PARALLEL  = 3'd1,
        OUT_U_OUTSIDE = 3'd2,
        OUT_V_OUTSIDE = 3'd3,
        OUT_BEHIND    = 3'd4
    } t_outcome;

endpackage

`default_nettype wire

// File: hw/rtl/rti_cfg.sv
// ----------------------------------------------------------------------------
// rti_cfg
// apb register file for the triangle and the threshold, with registered edge vectors
// ----------------------------------------------------------------------------
`default_nettype none

module rti_cfg #(
    parameter int COORD_WIDTH = rti_pkg::RTI_COORD_WIDTH,
    parameter int DATA_W      = 64,
    parameter int IDX_LSB     = 3,
    parameter int ADDR_W      = 5
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [ADDR_W-1:0]                  paddr,
    input  wire logic [DATA_W-1:0]                  pwdata,
    output logic      [DATA_W-1:0]                  prdata,
    output logic                                    pready,
    output logic signed [COORD_WIDTH-1:0]           o_vert_a [3],
    output logic signed [COORD_WIDTH:0]             o_e1 [3],
    output logic signed [COORD_WIDTH:0]             o_e2 [3],
    output logic [rti_pkg::THR_WIDTH-1:0]           o_thr
);
    import rti_pkg::*;

    localparam int VW = 3 * COORD_WIDTH;
    localparam int EW = COORD_WIDTH + 1;

    logic [VW-1:0]        r_vert [3];
    logic [THR_WIDTH-1:0] r_thr;
    logic signed [EW-1:0] r_e1 [3];
    logic signed [EW-1:0] r_e2 [3];
    logic                 wr;
    t_reg_idx             idx;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite && pready;
    assign idx    = t_reg_idx'(paddr[ADDR_W-1:IDX_LSB]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vert[0] <= '0;
            r_vert[1] <= '0;
            r_vert[2] <= '0;
            r_thr     <= THR_RESET;
        end else if (wr) begin
            unique case (idx)
                REG_VERTEX_A:  r_vert[0] <= pwdata[VW-1:0];
                REG_VERTEX_B:  r_vert[1] <= pwdata[VW-1:0];
                REG_VERTEX_C:  r_vert[2] <= pwdata[VW-1:0];
                REG_THRESHOLD: r_thr     <= pwdata[THR_WIDTH-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_VERTEX_A:  prdata = DATA_W'(r_vert[0]);
            REG_VERTEX_B:  prdata = DATA_W'(r_vert[1]);
            REG_VERTEX_C:  prdata = DATA_W'(r_vert[2]);
            REG_THRESHOLD: prdata = DATA_W'(r_thr);
        endcase
    end

    // edges are registered from the vertex registers in the cycle after they change
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_e1[i] <= EW'($signed(r_vert[1][i*COORD_WIDTH +: COORD_WIDTH]))
                     - EW'($signed(r_vert[0][i*COORD_WIDTH +: COORD_WIDTH]));
            r_e2[i] <= EW'($signed(r_vert[2][i*COORD_WIDTH +: COORD_WIDTH]))
                     - EW'($signed(r_vert[0][i*COORD_WIDTH +: COORD_WIDTH]));
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            o_vert_a[i] = $signed(r_vert[0][i*COORD_WIDTH +: COORD_WIDTH]);
            o_e1[i]     = r_e1[i];
            o_e2[i]     = r_e2[i];
        end
    end

    assign o_thr = r_thr;

endmodule

`default_nettype wire

// File: hw/rtl/rti_cross.sv
// ----------------------------------------------------------------------------
// rti_cross
// stages 1-3: origin offset, cross product terms, h = dir x e2, q = s x e1
// ----------------------------------------------------------------------------
`default_nettype none

module rti_cross #(
    parameter int COORD_WIDTH = rti_pkg::RTI_COORD_WIDTH
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_valid,
    output logic                                  o_ready,
    input  wire logic signed [COORD_WIDTH-1:0]    i_org [3],
    input  wire logic signed [COORD_WIDTH-1:0]    i_dir [3],
    input  wire logic signed [COORD_WIDTH-1:0]    i_vert_a [3],
    input  wire logic signed [COORD_WIDTH:0]      i_e1 [3],
    input  wire logic signed [COORD_WIDTH:0]      i_e2 [3],
    output logic                                  o_valid,
    input  wire logic                             i_ready,
    output logic signed [COORD_WIDTH:0]           o_s [3],
    output logic signed [COORD_WIDTH-1:0]         o_dir [3],
    output logic signed [2*COORD_WIDTH+1:0]       o_h [3],
    output logic signed [2*COORD_WIDTH+2:0]       o_q [3]
);
    import rti_pkg::*;

    localparam int W   = COORD_WIDTH;
    localparam int EW  = W + 1;
    localparam int HPW = 2 * W + 1;
    localparam int HW  = 2 * W + 2;
    localparam int QPW = 2 * W + 2;
    localparam int QW  = 2 * W + 3;
    localparam int J [3] = '{1, 2, 0};
    localparam int K [3] = '{2, 0, 1};

    logic r_vld1, r_vld2, r_vld3;
    logic rdy1, rdy2, rdy3;

    logic signed [EW-1:0]  r_s1 [3];
    logic signed [W-1:0]   r_d1 [3];
    logic signed [HPW-1:0] r_hp [3];
    logic signed [HPW-1:0] r_hn [3];
    logic signed [QPW-1:0] r_qp [3];
    logic signed [QPW-1:0] r_qn [3];
    logic signed [EW-1:0]  r_s2 [3];
    logic signed [W-1:0]   r_d2 [3];
    logic signed [HW-1:0]  r_h  [3];
    logic signed [QW-1:0]  r_q  [3];
    logic signed [EW-1:0]  r_s3 [3];
    logic signed [W-1:0]   r_d3 [3];

    assign rdy3    = !r_vld3 || i_ready;
    assign rdy2    = !r_vld2 || rdy3;
    assign rdy1    = !r_vld1 || rdy2;
    assign o_ready = rdy1;
    assign o_valid = r_vld3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
        end else begin
            if (rdy1) r_vld1 <= i_valid;
            if (rdy2) r_vld2 <= r_vld1;
            if (rdy3) r_vld3 <= r_vld2;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            if (rdy1) begin
                r_s1[i] <= EW'(i_org[i]) - EW'(i_vert_a[i]);
                r_d1[i] <= i_dir[i];
            end
            if (rdy2) begin
                r_hp[i] <= HPW'(r_d1[J[i]]) * HPW'(i_e2[K[i]]);
                r_hn[i] <= HPW'(r_d1[K[i]]) * HPW'(i_e2[J[i]]);
                r_qp[i] <= QPW'(r_s1[J[i]]) * QPW'(i_e1[K[i]]);
                r_qn[i] <= QPW'(r_s1[K[i]]) * QPW'(i_e1[J[i]]);
                r_s2[i] <= r_s1[i];
                r_d2[i] <= r_d1[i];
            end
            if (rdy3) begin
                r_h[i]  <= HW'(r_hp[i]) - HW'(r_hn[i]);
                r_q[i]  <= QW'(r_qp[i]) - QW'(r_qn[i]);
                r_s3[i] <= r_s2[i];
                r_d3[i] <= r_d2[i];
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            o_s[i]   = r_s3[i];
            o_dir[i] = r_d3[i];
            o_h[i]   = r_h[i];
            o_q[i]   = r_q[i];
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/rti_dot.sv
// ----------------------------------------------------------------------------
// rti_dot
// stages 4-5: dot product terms and sums for a, u, v and t numerators
// ----------------------------------------------------------------------------
`default_nettype none

module rti_dot #(
    parameter int COORD_WIDTH = rti_pkg::RTI_COORD_WIDTH
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_valid,
    output logic                                  o_ready,
    input  wire logic signed [COORD_WIDTH:0]      i_s [3],
    input  wire logic signed [COORD_WIDTH-1:0]    i_dir [3],
    input  wire logic signed [2*COORD_WIDTH+1:0]  i_h [3],
    input  wire logic signed [2*COORD_WIDTH+2:0]  i_q [3],
    input  wire logic signed [COORD_WIDTH:0]      i_e1 [3],
    input  wire logic signed [COORD_WIDTH:0]      i_e2 [3],
    output logic                                  o_valid,
    input  wire logic                             i_ready,
    output logic signed [3*COORD_WIDTH+5:0]       o_a,
    output logic signed [3*COORD_WIDTH+5:0]       o_un,
    output logic signed [3*COORD_WIDTH+5:0]       o_vn,
    output logic signed [3*COORD_WIDTH+5:0]       o_tn
);
    import rti_pkg::*;

    localparam int PW = 3 * COORD_WIDTH + 4;
    localparam int DW = 3 * COORD_WIDTH + 6;

    logic r_vld4, r_vld5;
    logic rdy4, rdy5;

    logic signed [PW-1:0] r_pa [3];
    logic signed [PW-1:0] r_pu [3];
    logic signed [PW-1:0] r_pv [3];
    logic signed [PW-1:0] r_pt [3];
    logic signed [DW-1:0] r_a, r_un, r_vn, r_tn;

    assign rdy5    = !r_vld5 || i_ready;
    assign rdy4    = !r_vld4 || rdy5;
    assign o_ready = rdy4;
    assign o_valid = r_vld5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld4 <= 1'b0;
            r_vld5 <= 1'b0;
        end else begin
            if (rdy4) r_vld4 <= i_valid;
            if (rdy5) r_vld5 <= r_vld4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy4) begin
            for (int i = 0; i < 3; i++) begin
                r_pa[i] <= PW'(i_e1[i])  * PW'(i_h[i]);
                r_pu[i] <= PW'(i_s[i])   * PW'(i_h[i]);
                r_pv[i] <= PW'(i_dir[i]) * PW'(i_q[i]);
                r_pt[i] <= PW'(i_e2[i])  * PW'(i_q[i]);
            end
        end
        if (rdy5) begin
            r_a  <= DW'(r_pa[0]) + DW'(r_pa[1]) + DW'(r_pa[2]);
            r_un <= DW'(r_pu[0]) + DW'(r_pu[1]) + DW'(r_pu[2]);
            r_vn <= DW'(r_pv[0]) + DW'(r_pv[1]) + DW'(r_pv[2]);
            r_tn <= DW'(r_pt[0]) + DW'(r_pt[1]) + DW'(r_pt[2]);
        end
    end

    assign o_a  = r_a;
    assign o_un = r_un;
    assign o_vn = r_vn;
    assign o_tn = r_tn;

endmodule

`default_nettype wire

// File: hw/rtl/rti_decide.sv
// ----------------------------------------------------------------------------
// rti_decide
// stages 6-7: sign adjust by the determinant, range tests, outcome register
// ----------------------------------------------------------------------------
`default_nettype none
`include "ray_triangle_intersect_assert.svh"

module rti_decide #(
    parameter int COORD_WIDTH = rti_pkg::RTI_COORD_WIDTH
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_valid,
    output logic                                  o_ready,
    input  wire logic signed [3*COORD_WIDTH+5:0]  i_a,
    input  wire logic signed [3*COORD_WIDTH+5:0]  i_un,
    input  wire logic signed [3*COORD_WIDTH+5:0]  i_vn,
    input  wire logic signed [3*COORD_WIDTH+5:0]  i_tn,
    input  wire logic [rti_pkg::THR_WIDTH-1:0]    i_thr,
    output logic                                  o_valid,
    input  wire logic                             i_ready,
    output logic                                  o_hit,
    output rti_pkg::t_outcome                     o_outcome
);
    import rti_pkg::*;

    localparam int DW = 3 * COORD_WIDTH + 6;
    localparam int XW = DW + 2;

    logic r_vld6, r_vld7;
    logic rdy6, rdy7;

    logic                 neg;
    logic signed [XW-1:0] n_absa, n_su, n_sv, n_st;
    logic signed [XW-1:0] r_absa, r_su, r_sv, r_st;
    logic                 r_azero;
    logic signed [XW-1:0] thr_x;
    logic signed [XW-1:0] sum_uv;
    t_outcome             n_code;
    t_outcome             r_code;
    logic                 r_hit;

    assign rdy7    = !r_vld7 || i_ready;
    assign rdy6    = !r_vld6 || rdy7;
    assign o_ready = rdy6;
    assign o_valid = r_vld7;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld6 <= 1'b0;
            r_vld7 <= 1'b0;
        end else begin
            if (rdy6) r_vld6 <= i_valid;
            if (rdy7) r_vld7 <= r_vld6;
        end
    end

    always_comb begin
        neg    = i_a[DW-1];
        n_absa = neg ? -XW'(i_a)  : XW'(i_a);
        n_su   = neg ? -XW'(i_un) : XW'(i_un);
        n_sv   = neg ? -XW'(i_vn) : XW'(i_vn);
        n_st   = neg ? -XW'(i_tn) : XW'(i_tn);
    end

    always_ff @(posedge i_clk) begin
        if (rdy6) begin
            r_absa  <= n_absa;
            r_su    <= n_su;
            r_sv    <= n_sv;
            r_st    <= n_st;
            r_azero <= (i_a == '0);
        end
    end

    assign thr_x  = XW'(i_thr);
    assign sum_uv = r_su + r_sv;

    always_comb begin
        priority if (r_azero || (r_absa < thr_x)) begin
            n_code = OUT_PARALLEL;
        end else if (r_su[XW-1] || (r_su > r_absa)) begin
            n_code = OUT_U_OUTSIDE;
        end else if (r_sv[XW-1] || (sum_uv > r_absa)) begin
            n_code = OUT_V_OUTSIDE;
        end else if (r_st[XW-1] || (r_st == '0)) begin
            n_code = OUT_BEHIND;
        end else begin
            n_code = OUT_HIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy7) begin
            r_code <= n_code;
            r_hit  <= (n_code == OUT_HIT);
        end
    end

    assign o_hit     = r_hit;
    assign o_outcome = r_code;

    `RTI_ASSERT_IMP(a_abs_nonneg, i_clk, i_rst_n, r_vld6, !r_absa[XW-1], "negative magnitude")
    `RTI_ASSERT_IMP(a_zero_abs, i_clk, i_rst_n, r_vld6 && r_azero, r_absa == '0, "zero det mismatch")
    `RTI_ASSERT_NXT(a_s6_hold, i_clk, i_rst_n, r_vld6 && !rdy7, r_vld6 && $stable(r_absa), "stage 6 item lost")
    `RTI_ASSERT_NXT(a_s6_move, i_clk, i_rst_n, r_vld6 && rdy7, r_vld7, "stage 6 item not advanced")

endmodule

`default_nettype wire

// File: hw/rtl/ray_triangle_intersect.sv
// ----------------------------------------------------------------------------
// ray_triangle_intersect
// moller-trumbore ray / triangle test, seven stage pipeline
// ----------------------------------------------------------------------------
// One ray enters per clock as long as the output side keeps tready high;
// backpressure only holds items in place. The rate is set by the fully
// pipelined multiplier stages: the cross products and the dot products
// each have a register stage of their own, followed by a register stage
// for their differences or sums. The triangle must be written over apb
// only while no ray is in flight; the block itself does not enforce this.
// Edge vectors are registered from the vertices in the cycle after a write.
`default_nettype none

module ray_triangle_intersect #(
    parameter int COORD_WIDTH = rti_pkg::RTI_COORD_WIDTH,
    localparam int DATA_W  = ((3 * COORD_WIDTH + 31) / 32) * 32,
    localparam int IDX_LSB = (DATA_W > 32) ? 3 : 2,
    localparam int ADDR_W  = IDX_LSB + 2,
    localparam int IN_W    = ((6 * COORD_WIDTH + 7) / 8) * 8
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_s_tvalid,
    output logic                                o_s_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
    input  wire logic [IN_W-1:0]                i_s_tdata,
    output logic                                o_m_tvalid,
    input  wire logic                           i_m_tready,
    // hit, outcome
    output logic [rti_pkg::OUT_WIDTH-1:0]       o_m_tdata,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [ADDR_W-1:0]              paddr,
    input  wire logic [DATA_W-1:0]              pwdata,
    output logic      [DATA_W-1:0]              prdata,
    output logic                                pready
);
    import rti_pkg::*;

    localparam int W = COORD_WIDTH;

    logic signed [W-1:0]     org [3];
    logic signed [W-1:0]     dir [3];
    logic signed [W-1:0]     vert_a [3];
    logic signed [W:0]       e1 [3];
    logic signed [W:0]       e2 [3];
    logic [THR_WIDTH-1:0]    thr;

    logic                    cr_valid, cr_ready;
    logic signed [W:0]       cr_s [3];
    logic signed [W-1:0]     cr_dir [3];
    logic signed [2*W+1:0]   cr_h [3];
    logic signed [2*W+2:0]   cr_q [3];

    logic                    dt_valid, dt_ready;
    logic signed [3*W+5:0]   dt_a, dt_un, dt_vn, dt_tn;

    logic                    hit;
    t_outcome                outcome;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            org[i] = $signed(i_s_tdata[i*W +: W]);
            dir[i] = $signed(i_s_tdata[(i+3)*W +: W]);
        end
    end

    rti_cfg #(
        .COORD_WIDTH (COORD_WIDTH),
        .DATA_W      (DATA_W),
        .IDX_LSB     (IDX_LSB),
        .ADDR_W      (ADDR_W)
    ) u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_vert_a (vert_a),
        .o_e1     (e1),
        .o_e2     (e2),
        .o_thr    (thr)
    );

    rti_cross #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_cross (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_tvalid),
        .o_ready  (o_s_tready),
        .i_org    (org),
        .i_dir    (dir),
        .i_vert_a (vert_a),
        .i_e1     (e1),
        .i_e2     (e2),
        .o_valid  (cr_valid),
        .i_ready  (cr_ready),
        .o_s      (cr_s),
        .o_dir    (cr_dir),
        .o_h      (cr_h),
        .o_q      (cr_q)
    );

    rti_dot #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_dot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (cr_valid),
        .o_ready (cr_ready),
        .i_s     (cr_s),
        .i_dir   (cr_dir),
        .i_h     (cr_h),
        .i_q     (cr_q),
        .i_e1    (e1),
        .i_e2    (e2),
        .o_valid (dt_valid),
        .i_ready (dt_ready),
        .o_a     (dt_a),
        .o_un    (dt_un),
        .o_vn    (dt_vn),
        .o_tn    (dt_tn)
    );

    rti_decide #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_decide (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (dt_valid),
        .o_ready   (dt_ready),
        .i_a       (dt_a),
        .i_un      (dt_un),
        .i_vn      (dt_vn),
        .i_tn      (dt_tn),
        .i_thr     (thr),
        .o_valid   (o_m_tvalid),
        .i_ready   (i_m_tready),
        .o_hit     (hit),
        .o_outcome (outcome)
    );

    assign o_m_tdata = {4'd0, outcome, hit};

endmodule

`default_nettype wire
